// File: rtl/core/tcba_pkg.sv
// Shared types and constants for the three-class block allocator.
// Depends on nothing; tcba_binfo and the allocator refer to it by scoped names.
package tcba_pkg;

    localparam int MAX_BLOCKS       = 256;
    localparam int MEDIUM_PER_BLOCK = 4;
    localparam int SMALL_PER_BLOCK  = 8;
    localparam int BLK_W            = 8;
    localparam int MED_SB           = 2;
    localparam int SML_SB           = 3;
    localparam int MED_HW           = BLK_W + MED_SB;
    localparam int SML_HW           = BLK_W + SML_SB;
    localparam int MED_DEPTH        = MAX_BLOCKS * MEDIUM_PER_BLOCK;
    localparam int SML_DEPTH        = MAX_BLOCKS * SMALL_PER_BLOCK;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_LARGE  = 2'd1,
        KIND_MEDIUM = 2'd2,
        KIND_SMALL  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADSIZE = 2'd2,
        ST_BADFREE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CLS_LARGE   = 2'd0,
        CLS_MEDIUM  = 2'd1,
        CLS_SMALL   = 2'd2,
        CLS_INVALID = 2'd3
    } size_cls_t;

    localparam logic REQ_ALLOC = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAKE,
        S_TAKE_WAIT,
        S_TAKEN,
        S_SPLIT,
        S_POP_RD,
        S_POP_WAIT,
        S_POP_INFO,
        S_FREE_CHK,
        S_WALK,
        S_OUT
    } state_t;

    // one entry of the block table
    typedef struct packed {
        kind_t      kind;
        logic [7:0] taken;
    } binfo_t;

endpackage

// File: rtl/core/tcba_ram.sv
// Simple one-write one-read RAM with registered read data.
// Used for the three free stacks; depends on nothing.
module tcba_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/tcba_binfo.sv
// Block table: kind and taken mask per block, with a valid bit per entry.
// Entries not written since reset read as uncarved, nothing taken. Uses tcba_pkg.
module tcba_binfo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 re,
    input  logic [7:0]           raddr,
    output tcba_pkg::binfo_t     rdata,
    input  logic                 we,
    input  logic [7:0]           waddr,
    input  tcba_pkg::binfo_t     wdata
);

    tcba_pkg::binfo_t mem [tcba_pkg::MAX_BLOCKS];
    logic [tcba_pkg::MAX_BLOCKS-1:0] valid_reg;
    tcba_pkg::binfo_t rd_reg;
    logic             rd_valid_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    // valid bits and registered valid of the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : tcba_pkg::binfo_t'('0);

endmodule

// File: rtl/core/three_class_block_allocator.sv
// Three-class block allocator: sequencer, counters and free stacks.
// Uses tcba_pkg, tcba_ram and tcba_binfo.
// Paths: invalid size, null or block-zero free go straight out; a free reads the
// block table; large alloc takes a fresh block, pops the large stack or gives no
// space; medium or small pops the class stack or splits a block; a merging free
// walks the class stack. A new item is taken only after the last result is registered.
// Reset: stack counts cleared, fresh index set to 1, block table valid bits cleared at once, no clearing pass.
module three_class_block_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // size_class[1:0], free_block[9:2], free_slot[12:10],
                                   // free_null[13], zero[15:14]
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[1:0], got_block[9:2], got_slot[12:10],
                                   // merged[13], zero[15:14]
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata
);

    tcba_pkg::state_t state_reg, state_next;

    logic [8:0]  pool_reg;
    logic [8:0]  fresh_reg, fresh_next;
    logic [8:0]  lcnt_reg, lcnt_next;
    logic [10:0] mcnt_reg, mcnt_next;
    logic [11:0] scnt_reg, scnt_next;
    logic        req_reg;
    logic [1:0]  cls_reg;
    logic [7:0]  fb_reg;
    logic [2:0]  fs_reg;
    logic        small_reg, small_next;
    logic [7:0]  blk_reg, blk_next;
    logic [2:0]  idx_reg, idx_next;
    logic [11:0] ri_reg, ri_next;
    logic [11:0] wi_reg, wi_next;
    logic        pend_reg, pend_next;
    logic [1:0]  rst_reg, rst_next;
    logic [7:0]  rblk_reg, rblk_next;
    logic [2:0]  rslot_reg, rslot_next;
    logic        rmrg_reg, rmrg_next;
    logic        mval_reg, mval_next;
    logic [15:0] mdat_reg, mdat_next;

    // memory controls
    logic        l_we, l_re, st_we, st_re, bi_we, bi_re;
    logic [7:0]  l_waddr, l_wdata, l_raddr, l_rdata;
    logic [10:0] st_waddr, st_wdata, st_raddr, stk_rdata;
    logic [9:0]  m_rdata;
    logic [10:0] s_rdata;
    logic [7:0]  bi_raddr, bi_waddr;
    tcba_pkg::binfo_t bi_rdata, bi_wdata;

    // decode
    logic        accept, stk_small, fresh_ok;
    logic [8:0]  limit;
    logic [11:0] cnt_cur;
    logic [7:0]  fbit, ntaken, rd_blk;
    logic        lg_ok, md_ok, sm_ok, sl_ok, do_merge, walk_re, walk_done;
    logic [1:0]  in_cls;
    logic [7:0]  in_fb;
    logic        in_null;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == tcba_pkg::S_IDLE);
    assign in_cls   = s_tdata[1:0];
    assign in_fb    = s_tdata[9:2];
    assign in_null  = s_tdata[13];
    assign limit    = (pool_reg > 9'(tcba_pkg::MAX_BLOCKS)) ?
                      9'(tcba_pkg::MAX_BLOCKS) : pool_reg;
    assign fresh_ok = fresh_reg < limit;

    // class stack in use: in the free check it follows the block kind
    assign stk_small = (state_reg == tcba_pkg::S_FREE_CHK) ?
                       (bi_rdata.kind == tcba_pkg::KIND_SMALL) : small_reg;
    assign cnt_cur   = stk_small ? scnt_reg : {1'b0, mcnt_reg};
    assign stk_rdata = stk_small ? s_rdata : {1'b0, m_rdata};
    assign rd_blk    = stk_small ? stk_rdata[10:3] : stk_rdata[9:2];

    // free checks
    assign fbit   = 8'b1 << fs_reg;
    assign ntaken = bi_rdata.taken & ~fbit;
    assign lg_ok  = (bi_rdata.kind == tcba_pkg::KIND_LARGE) && (fs_reg == 3'd0)
                    && bi_rdata.taken[0];
    assign md_ok  = (bi_rdata.kind == tcba_pkg::KIND_MEDIUM) && !fs_reg[2]
                    && ((bi_rdata.taken & fbit) != 8'd0);
    assign sm_ok  = (bi_rdata.kind == tcba_pkg::KIND_SMALL)
                    && ((bi_rdata.taken & fbit) != 8'd0);
    assign sl_ok    = md_ok || sm_ok;
    assign do_merge = sl_ok && (ntaken == 8'd0);

    // compaction walk
    assign walk_re   = ri_reg < cnt_cur;
    assign walk_done = !walk_re && !pend_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] == tcba_pkg::REQ_ALLOC)
                    begin
                        unique case (in_cls)
                            tcba_pkg::CLS_LARGE:   state_next = tcba_pkg::S_TAKE;
                            tcba_pkg::CLS_MEDIUM:  state_next = (mcnt_reg == 11'd0) ?
                                                   tcba_pkg::S_TAKE : tcba_pkg::S_POP_RD;
                            tcba_pkg::CLS_SMALL:   state_next = (scnt_reg == 12'd0) ?
                                                   tcba_pkg::S_TAKE : tcba_pkg::S_POP_RD;
                            default:               state_next = tcba_pkg::S_OUT;
                        endcase
                    end
                    else if (in_null || in_fb == 8'd0)
                    begin
                        state_next = tcba_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = tcba_pkg::S_FREE_CHK;
                    end
                end
            end
            tcba_pkg::S_TAKE:
            begin
                priority if (fresh_ok)
                    state_next = tcba_pkg::S_TAKEN;
                else if (lcnt_reg != 9'd0)
                    state_next = tcba_pkg::S_TAKE_WAIT;
                else
                    state_next = tcba_pkg::S_OUT;
            end
            tcba_pkg::S_TAKE_WAIT: state_next = tcba_pkg::S_TAKEN;
            tcba_pkg::S_TAKEN:
            begin
                state_next = (cls_reg == tcba_pkg::CLS_LARGE) ?
                             tcba_pkg::S_OUT : tcba_pkg::S_SPLIT;
            end
            tcba_pkg::S_SPLIT:
            begin
                if (idx_reg == (small_reg ? 3'(tcba_pkg::SMALL_PER_BLOCK - 2)
                                          : 3'(tcba_pkg::MEDIUM_PER_BLOCK - 2)))
                begin
                    state_next = tcba_pkg::S_OUT;
                end
            end
            tcba_pkg::S_POP_RD:   state_next = tcba_pkg::S_POP_WAIT;
            tcba_pkg::S_POP_WAIT: state_next = tcba_pkg::S_POP_INFO;
            tcba_pkg::S_POP_INFO: state_next = tcba_pkg::S_OUT;
            tcba_pkg::S_FREE_CHK:
            begin
                state_next = do_merge ? tcba_pkg::S_WALK : tcba_pkg::S_OUT;
            end
            tcba_pkg::S_WALK:
            begin
                if (walk_done)
                begin
                    state_next = tcba_pkg::S_OUT;
                end
            end
            tcba_pkg::S_OUT:
            begin
                if (!mval_reg || m_tready)
                begin
                    state_next = tcba_pkg::S_IDLE;
                end
            end
            default: state_next = tcba_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        fresh_next = fresh_reg;
        lcnt_next  = lcnt_reg;
        mcnt_next  = mcnt_reg;
        scnt_next  = scnt_reg;
        small_next = small_reg;
        blk_next   = blk_reg;
        idx_next   = idx_reg;
        ri_next    = ri_reg;
        wi_next    = wi_reg;
        pend_next  = 1'b0;
        rst_next   = rst_reg;
        rblk_next  = rblk_reg;
        rslot_next = rslot_reg;
        rmrg_next  = rmrg_reg;
        mval_next  = mval_reg && !m_tready;
        mdat_next  = mdat_reg;
        l_we = 1'b0; l_waddr = lcnt_reg[7:0]; l_wdata = fb_reg;
        l_re = 1'b0; l_raddr = 8'(lcnt_reg - 9'd1);
        st_we = 1'b0; st_waddr = cnt_cur[10:0]; st_wdata = '0;
        st_re = 1'b0; st_raddr = 11'(cnt_cur - 12'd1);
        bi_we = 1'b0; bi_waddr = blk_reg; bi_wdata = bi_rdata;
        bi_re = 1'b0; bi_raddr = in_fb;

        unique case (state_reg)
            tcba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rst_next   = tcba_pkg::ST_OK;
                    rblk_next  = 8'd0;
                    rslot_next = 3'd0;
                    rmrg_next  = 1'b0;
                    small_next = (in_cls == tcba_pkg::CLS_SMALL);
                    if (s_tuser[0] == tcba_pkg::REQ_ALLOC)
                    begin
                        if (in_cls == tcba_pkg::CLS_INVALID)
                        begin
                            rst_next = tcba_pkg::ST_BADSIZE;
                        end
                    end
                    else if (in_null || in_fb == 8'd0)
                    begin
                        rst_next = tcba_pkg::ST_BADFREE;
                    end
                    else
                    begin
                        bi_re = 1'b1;
                    end
                end
            end
            tcba_pkg::S_TAKE:
            begin
                priority if (fresh_ok)
                begin
                    blk_next   = fresh_reg[7:0];
                    fresh_next = fresh_reg + 9'd1;
                end
                else if (lcnt_reg != 9'd0)
                begin
                    l_re      = 1'b1;
                    lcnt_next = lcnt_reg - 9'd1;
                end
                else
                begin
                    rst_next = tcba_pkg::ST_NOSPACE;
                end
            end
            tcba_pkg::S_TAKE_WAIT: blk_next = l_rdata;
            tcba_pkg::S_TAKEN:
            begin
                bi_we    = 1'b1;
                idx_next = 3'd0;
                if (cls_reg == tcba_pkg::CLS_LARGE)
                begin
                    bi_wdata  = '{kind: tcba_pkg::KIND_LARGE, taken: 8'd1};
                    rblk_next = blk_reg;
                end
                else if (small_reg)
                begin
                    bi_wdata = '{kind: tcba_pkg::KIND_SMALL,
                                 taken: 8'(1 << (tcba_pkg::SMALL_PER_BLOCK - 1))};
                end
                else
                begin
                    bi_wdata = '{kind: tcba_pkg::KIND_MEDIUM,
                                 taken: 8'(1 << (tcba_pkg::MEDIUM_PER_BLOCK - 1))};
                end
            end
            tcba_pkg::S_SPLIT:
            begin
                // push the lower slots; the top slot goes straight out
                st_we    = 1'b1;
                st_wdata = small_reg ? {blk_reg, idx_reg} : {1'b0, blk_reg, idx_reg[1:0]};
                idx_next = idx_reg + 3'd1;
                if (small_reg)
                    scnt_next = scnt_reg + 12'd1;
                else
                    mcnt_next = mcnt_reg + 11'd1;
                rblk_next  = blk_reg;
                rslot_next = small_reg ? 3'(tcba_pkg::SMALL_PER_BLOCK - 1)
                                       : 3'(tcba_pkg::MEDIUM_PER_BLOCK - 1);
            end
            tcba_pkg::S_POP_RD:
            begin
                st_re = 1'b1;
                if (small_reg)
                    scnt_next = scnt_reg - 12'd1;
                else
                    mcnt_next = mcnt_reg - 11'd1;
            end
            tcba_pkg::S_POP_WAIT:
            begin
                blk_next   = rd_blk;
                idx_next   = small_reg ? stk_rdata[2:0] : {1'b0, stk_rdata[1:0]};
                bi_re      = 1'b1;
                bi_raddr   = rd_blk;
            end
            tcba_pkg::S_POP_INFO:
            begin
                bi_we      = 1'b1;
                bi_wdata   = '{kind: bi_rdata.kind, taken: bi_rdata.taken | (8'b1 << idx_reg)};
                rblk_next  = blk_reg;
                rslot_next = idx_reg;
            end
            tcba_pkg::S_FREE_CHK:
            begin
                small_next = stk_small;
                ri_next    = 12'd0;
                wi_next    = 12'd0;
                bi_waddr   = fb_reg;
                rst_next   = tcba_pkg::ST_BADFREE;
                if (lg_ok)
                begin
                    rst_next  = tcba_pkg::ST_OK;
                    bi_we     = 1'b1;
                    bi_wdata  = '{kind: tcba_pkg::KIND_LARGE, taken: 8'd0};
                    l_we      = 1'b1;
                    lcnt_next = lcnt_reg + 9'd1;
                end
                else if (sl_ok)
                begin
                    rst_next = tcba_pkg::ST_OK;
                    if (!do_merge)
                    begin
                        bi_we    = 1'b1;
                        bi_wdata = '{kind: bi_rdata.kind, taken: ntaken};
                        st_we    = 1'b1;
                        st_wdata = stk_small ? {fb_reg, fs_reg} : {1'b0, fb_reg, fs_reg[1:0]};
                        if (stk_small)
                            scnt_next = scnt_reg + 12'd1;
                        else
                            mcnt_next = mcnt_reg + 11'd1;
                    end
                end
            end
            tcba_pkg::S_WALK:
            begin
                // read entry ri, keep last entry read if it is another block
                st_re     = walk_re;
                st_raddr  = ri_reg[10:0];
                pend_next = walk_re;
                if (walk_re)
                    ri_next = ri_reg + 12'd1;
                st_waddr = wi_reg[10:0];
                st_wdata = stk_rdata;
                if (pend_reg && rd_blk != fb_reg)
                begin
                    st_we   = 1'b1;
                    wi_next = wi_reg + 12'd1;
                end
                if (walk_done)
                begin
                    if (small_reg)
                        scnt_next = wi_reg;
                    else
                        mcnt_next = wi_reg[10:0];
                    bi_we     = 1'b1;
                    bi_waddr  = fb_reg;
                    bi_wdata  = '{kind: tcba_pkg::KIND_LARGE, taken: 8'd0};
                    l_we      = 1'b1;
                    lcnt_next = lcnt_reg + 9'd1;
                    rmrg_next = 1'b1;
                end
            end
            tcba_pkg::S_OUT:
            begin
                if (!mval_reg || m_tready)
                begin
                    mval_next = 1'b1;
                    mdat_next = {2'b00, rmrg_reg, rslot_reg, rblk_reg, rst_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcba_pkg::S_IDLE;
            pool_reg  <= 9'd256;
            fresh_reg <= 9'd1;
            lcnt_reg  <= 9'd0;
            mcnt_reg  <= 11'd0;
            scnt_reg  <= 12'd0;
            pend_reg  <= 1'b0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                pool_reg <= cfg_wdata;
            fresh_reg <= fresh_next;
            lcnt_reg  <= lcnt_next;
            mcnt_reg  <= mcnt_next;
            scnt_reg  <= scnt_next;
            pend_reg  <= pend_next;
            mval_reg  <= mval_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= s_tuser[0];
            cls_reg <= in_cls;
            fb_reg  <= in_fb;
            fs_reg  <= s_tdata[12:10];
        end
        small_reg <= small_next;
        blk_reg   <= blk_next;
        idx_reg   <= idx_next;
        ri_reg    <= ri_next;
        wi_reg    <= wi_next;
        rst_reg   <= rst_next;
        rblk_reg  <= rblk_next;
        rslot_reg <= rslot_next;
        rmrg_reg  <= rmrg_next;
        mdat_reg  <= mdat_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdat_reg;

    // memories
    tcba_ram #(.DEPTH(tcba_pkg::MAX_BLOCKS), .WIDTH(tcba_pkg::BLK_W)) u_large (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
    );

    tcba_ram #(.DEPTH(tcba_pkg::MED_DEPTH), .WIDTH(tcba_pkg::MED_HW)) u_medium (
        .clk(clk), .we(st_we && !stk_small), .waddr(st_waddr[9:0]),
        .wdata(st_wdata[9:0]), .re(st_re && !stk_small), .raddr(st_raddr[9:0]),
        .rdata(m_rdata)
    );

    tcba_ram #(.DEPTH(tcba_pkg::SML_DEPTH), .WIDTH(tcba_pkg::SML_HW)) u_small (
        .clk(clk), .we(st_we && stk_small), .waddr(st_waddr), .wdata(st_wdata),
        .re(st_re && stk_small), .raddr(st_raddr), .rdata(s_rdata)
    );

    tcba_binfo u_binfo (
        .clk(clk), .rst_n(rst_n), .re(bi_re), .raddr(bi_raddr), .rdata(bi_rdata),
        .we(bi_we), .waddr(bi_waddr), .wdata(bi_wdata)
    );

    // checks
    a_lcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        lcnt_reg <= 9'(tcba_pkg::MAX_BLOCKS))
        else $error("large stack count out of range");
    a_fresh_range: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= 9'(tcba_pkg::MAX_BLOCKS))
        else $error("fresh block index out of range");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("item accepted while busy");
    a_merge_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcba_pkg::S_WALK) |-> (req_reg != tcba_pkg::REQ_ALLOC))
        else $error("stack walk on an allocate request");

endmodule
